/* rtl/mlpd_pkg.sv */
// ----------------------------------------------------------------------------
// mlpd_pkg
// Shared types and constants for the multi-level long-press detector.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpd_pkg;

  // field widths fixed by the interface
  localparam int DUR_W      = 20;
  localparam int LVL_W      = 3;
  localparam int NUM_THRESH = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

  // defaults for the top-level parameters
  localparam int DEFAULT_MAX_LEVELS = 5;
  localparam int DEFAULT_TIME_WIDTH = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_POLARITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_3    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_4    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_5    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD  = 3'd7;

  // register reset values
  localparam logic             RST_PRESS_POLARITY = 1'b0;
  localparam logic [LVL_W-1:0] RST_LEVEL_COUNT    = 3'd5;
  localparam logic [DUR_W-1:0] RST_THRESHOLD_1    = 20'd1000;
  localparam logic [DUR_W-1:0] RST_THRESHOLD_2    = 20'd2000;
  localparam logic [DUR_W-1:0] RST_THRESHOLD_3    = 20'd3000;
  localparam logic [DUR_W-1:0] RST_THRESHOLD_4    = 20'd4000;
  localparam logic [DUR_W-1:0] RST_THRESHOLD_5    = 20'd5000;
  localparam logic [DUR_W-1:0] RST_REPEAT_PERIOD  = 20'd5000;

  // configuration seen by the datapath
  typedef struct packed {
    logic                             press_polarity;
    logic [LVL_W-1:0]                 level_count;
    logic [NUM_THRESH-1:0][DUR_W-1:0] threshold;
    logic [DUR_W-1:0]                 repeat_period;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic             released;
    logic [DUR_W-1:0] press_duration;
    logic [LVL_W-1:0] press_level;
    logic             max_reached;
    logic             level_notify;
    logic             beep;
  } res_t;

endpackage

`default_nettype wire

/* rtl/mlpd_cfg.sv */
// ----------------------------------------------------------------------------
// mlpd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpd_cfg
  import mlpd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [DUR_W-1:0]     wr_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  // register writes, one index per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_polarity <= RST_PRESS_POLARITY;
      cfg_r.level_count    <= RST_LEVEL_COUNT;
      cfg_r.threshold[0]   <= RST_THRESHOLD_1;
      cfg_r.threshold[1]   <= RST_THRESHOLD_2;
      cfg_r.threshold[2]   <= RST_THRESHOLD_3;
      cfg_r.threshold[3]   <= RST_THRESHOLD_4;
      cfg_r.threshold[4]   <= RST_THRESHOLD_5;
      cfg_r.repeat_period  <= RST_REPEAT_PERIOD;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PRESS_POLARITY: cfg_r.press_polarity <= wr_data[0];
        REG_LEVEL_COUNT:    cfg_r.level_count    <= wr_data[LVL_W-1:0];
        REG_THRESHOLD_1:    cfg_r.threshold[0]   <= wr_data;
        REG_THRESHOLD_2:    cfg_r.threshold[1]   <= wr_data;
        REG_THRESHOLD_3:    cfg_r.threshold[2]   <= wr_data;
        REG_THRESHOLD_4:    cfg_r.threshold[3]   <= wr_data;
        REG_THRESHOLD_5:    cfg_r.threshold[4]   <= wr_data;
        REG_REPEAT_PERIOD:  cfg_r.repeat_period  <= wr_data;
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/mlpd_core.sv */
// ----------------------------------------------------------------------------
// mlpd_core
// Press tracking state and the per-tick level, notify and beep logic.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpd_core
  import mlpd_pkg::*;
#(
  parameter int MAX_LEVELS = DEFAULT_MAX_LEVELS,
  parameter int TIME_WIDTH = DEFAULT_TIME_WIDTH
)
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic tick_en,
  input  wire logic pin_level,
  input  wire cfg_t cfg,
  output res_t      res
);

  localparam int LVL_LIM = (MAX_LEVELS < NUM_THRESH) ? MAX_LEVELS : NUM_THRESH;
  localparam int CMP_W   = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;

  logic                  is_pressed_r,  is_pressed_nxt;
  logic                  timing_r,      timing_nxt;
  logic [TIME_WIDTH-1:0] held_r,        held_nxt;
  logic [LVL_W-1:0]      level_r,       level_nxt;
  logic                  max_flag_r,    max_flag_nxt;
  logic [LVL_W-1:0]      notified_r,    notified_nxt;
  logic [DUR_W-1:0]      beep_timer_r,  beep_timer_nxt;
  logic                  beep_start_r,  beep_start_nxt;

  logic             now;
  logic [LVL_W-1:0] n_used;

  // number of levels in use
  assign now    = (pin_level == cfg.press_polarity);
  assign n_used = (cfg.level_count > LVL_W'(LVL_LIM)) ? LVL_W'(LVL_LIM) : cfg.level_count;

  // next state and result for one tick
  always_comb begin
    logic             do_eval;
    logic [CMP_W-1:0] held_ext;
    logic [LVL_W-1:0] lvl;

    is_pressed_nxt = now;
    timing_nxt     = timing_r;
    held_nxt       = held_r;
    level_nxt      = level_r;
    max_flag_nxt   = max_flag_r;
    notified_nxt   = notified_r;
    beep_timer_nxt = beep_timer_r;
    beep_start_nxt = beep_start_r;
    res            = '0;
    do_eval        = 1'b0;

    // press, release or hold
    if (now && !is_pressed_r) begin
      timing_nxt     = 1'b1;
      held_nxt       = '0;
      level_nxt      = '0;
      max_flag_nxt   = 1'b0;
      notified_nxt   = '0;
      beep_timer_nxt = '0;
      beep_start_nxt = 1'b0;
      do_eval        = 1'b1;
    end else if (!now && is_pressed_r) begin
      if (timing_r) begin
        held_ext           = CMP_W'(held_r);
        res.released       = 1'b1;
        res.press_duration = (held_ext > CMP_W'(DUR_MAX)) ? DUR_MAX : held_ext[DUR_W-1:0];
        timing_nxt         = 1'b0;
      end
    end else if (now && timing_r) begin
      if (held_r != {TIME_WIDTH{1'b1}}) begin
        held_nxt = held_r + TIME_WIDTH'(1);
      end
      do_eval = 1'b1;
    end

    // level from the highest passed threshold, never falling
    held_ext = CMP_W'(held_nxt);
    lvl      = '0;
    for (int i = 1; i <= LVL_LIM; i++) begin
      if ((LVL_W'(i) <= n_used) && (held_ext >= CMP_W'(cfg.threshold[i-1]))) begin
        lvl = LVL_W'(i);
      end
    end
    if (do_eval) begin
      if (lvl > level_nxt) begin
        level_nxt = lvl;
      end
      if (level_nxt == n_used) begin
        max_flag_nxt = 1'b1;
      end
    end

    // notify and beep while held
    if (now) begin
      if (level_nxt != '0) begin
        if (level_nxt != notified_nxt) begin
          res.level_notify = 1'b1;
          notified_nxt     = level_nxt;
        end
        if (max_flag_nxt) begin
          if (!beep_start_nxt) begin
            res.beep       = 1'b1;
            beep_start_nxt = 1'b1;
            beep_timer_nxt = '0;
          end else begin
            if (beep_timer_nxt != DUR_MAX) begin
              beep_timer_nxt = beep_timer_nxt + DUR_W'(1);
            end
            if (beep_timer_nxt >= cfg.repeat_period) begin
              res.beep       = 1'b1;
              beep_timer_nxt = '0;
            end
          end
        end
      end
    end else begin
      notified_nxt   = '0;
      beep_timer_nxt = '0;
      beep_start_nxt = 1'b0;
    end

    res.press_level = level_nxt;
    res.max_reached = max_flag_nxt;
  end

  // state registers advance on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_pressed_r <= 1'b0;
      timing_r     <= 1'b0;
      held_r       <= '0;
      level_r      <= '0;
      max_flag_r   <= 1'b0;
      notified_r   <= '0;
      beep_timer_r <= '0;
      beep_start_r <= 1'b0;
    end else if (tick_en) begin
      is_pressed_r <= is_pressed_nxt;
      timing_r     <= timing_nxt;
      held_r       <= held_nxt;
      level_r      <= level_nxt;
      max_flag_r   <= max_flag_nxt;
      notified_r   <= notified_nxt;
      beep_timer_r <= beep_timer_nxt;
      beep_start_r <= beep_start_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/mlpd_obuf.sv */
// ----------------------------------------------------------------------------
// mlpd_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpd_obuf
  import mlpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire res_t in_res,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  logic push, pop;

  assign in_ready = !skid_v_r;
  assign push     = in_valid && in_ready;
  assign pop      = main_v_r && out_ready;

  // buffer fill and drain
  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_nxt = in_res;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_v_r) begin
        skid_nxt   = in_res;
        skid_v_nxt = 1'b1;
      end else begin
        main_nxt   = in_res;
        main_v_nxt = 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // occupancy flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  assign out_valid = main_v_r;
  assign out_res   = main_r;

endmodule

`default_nettype wire

/* rtl/multi_level_long_press_detector.sv */
// ----------------------------------------------------------------------------
// multi_level_long_press_detector
// Button long-press detector with up to five hold levels, notify and beep.
// ----------------------------------------------------------------------------
// Each input transfer is one millisecond tick carrying the sampled button pin,
// and each tick yields exactly one result transfer. The block takes one tick
// per clock cycle while input ready is high: the press state updates on every
// input transfer, and the result lands in a two-entry output buffer (output
// register plus skid register), so a tick is accepted even while an earlier
// result is still waiting; input ready drops only when both entries are full.
// Results are registered in the buffer. Configuration must be written through
// the cfg_ port while no tick is in flight; the block does not enforce this.
`default_nettype none

module multi_level_long_press_detector
  import mlpd_pkg::*;
#(
  parameter int MAX_LEVELS = DEFAULT_MAX_LEVELS,
  parameter int TIME_WIDTH = DEFAULT_TIME_WIDTH
)
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DUR_W-1:0]     cfg_wr_data,
  // tick input
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_pin_level,
  // results
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_released,
  output logic [DUR_W-1:0]          out_press_duration,
  output logic [LVL_W-1:0]          out_press_level,
  output logic                      out_max_reached,
  output logic                      out_level_notify,
  output logic                      out_beep
);

  localparam int LVL_LIM = (MAX_LEVELS < NUM_THRESH) ? MAX_LEVELS : NUM_THRESH;

  cfg_t cfg;
  res_t core_res;
  res_t buf_res;
  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  // configuration registers
  mlpd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wr_data),
    .cfg      (cfg)
  );

  // press tracking
  mlpd_core #(
    .MAX_LEVELS (MAX_LEVELS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_en   (in_xfer),
    .pin_level (in_pin_level),
    .cfg       (cfg),
    .res       (core_res)
  );

  // result buffer
  mlpd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_res    (core_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (buf_res)
  );

  assign out_released       = buf_res.released;
  assign out_press_duration = buf_res.press_duration;
  assign out_press_level    = buf_res.press_level;
  assign out_max_reached    = buf_res.max_reached;
  assign out_level_notify   = buf_res.level_notify;
  assign out_beep           = buf_res.beep;

  // a beep only happens at a nonzero top level
  a_beep_needs_max : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beep |-> out_max_reached && (out_press_level != '0))
    else $error("beep without top level reached");

  // a release tick never notifies or beeps
  a_release_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_released |-> !out_level_notify && !out_beep)
    else $error("notify or beep on release tick");

  // level stays within the levels that exist
  a_level_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_press_level <= LVL_W'(LVL_LIM)))
    else $error("press level out of range");

  // input stalls only when a result is waiting
  a_stall_has_result : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire
